@@ rtl/rtfd_pkg.sv @@
// Package for the radar target frame decoder: field widths, codes, the
// CORDIC angle table and the command/result types. No dependencies.
package rtfd_pkg;

    localparam int MaxTargets  = 64;
    localparam int CntW        = 7;
    localparam int CordicSteps = 17;
    localparam int StepW       = 5;
    localparam int HalfPiOut   = 12868;
    localparam int CmdDepth    = 2;
    localparam int AccW        = 32;
    localparam int ZW          = 20;
    localparam int SqW         = 28;

    localparam logic [1:0] REG_HEADER_ID = 2'd0;
    localparam logic [1:0] REG_TARGET_ID = 2'd1;

    localparam logic RESULT_TARGET = 1'b0;
    localparam logic RESULT_EMPTY  = 1'b1;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_RUN,
        BE_DONE
    } be_state_t;

    // work item handed from the front to the back
    typedef struct packed {
        logic              kind;
        logic [5:0]        index;
        logic              last;
        logic signed [14:0] dx;
        logic signed [12:0] dy;
        logic [9:0]        raw_vx;
        logic [2:0]        mclass;
        logic [7:0]        ego;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [5:0]        index;
        logic              last;
        logic signed [14:0] dx;
        logic signed [12:0] dy;
        logic [13:0]       range_v;
        logic signed [14:0] bearing;
        logic              invalid;
        logic signed [9:0] vx;
        logic [2:0]        mclass;
        logic [7:0]        ego;
    } res_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 20'd51472;
            5'd1:  v = 20'd30385;
            5'd2:  v = 20'd16055;
            5'd3:  v = 20'd8150;
            5'd4:  v = 20'd4091;
            5'd5:  v = 20'd2047;
            5'd6:  v = 20'd1024;
            5'd7:  v = 20'd512;
            5'd8:  v = 20'd256;
            5'd9:  v = 20'd128;
            5'd10: v = 20'd64;
            5'd11: v = 20'd32;
            5'd12: v = 20'd16;
            5'd13: v = 20'd8;
            5'd14: v = 20'd4;
            5'd15: v = 20'd2;
            5'd16: v = 20'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/rtfd_front.sv @@
// Front end: classifies CAN frames, keeps list counters and ego speed,
// unpacks target fields into commands. Depends on rtfd_pkg.
module rtfd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [10:0]          cfg_data,
    input  logic                 in_fire,
    input  logic [10:0]          frame_id,
    input  logic [7:0]           b0,
    input  logic [7:0]           b1,
    input  logic [7:0]           b2,
    input  logic [7:0]           b3,
    input  logic [7:0]           b4,
    input  logic [7:0]           b5,
    input  logic [7:0]           b6,
    output logic                 cmd_push,
    output rtfd_pkg::cmd_t       cmd
);

    logic [10:0] hdr_id_reg;
    logic [10:0] tgt_id_reg;
    logic [rtfd_pkg::CntW-1:0] exp_reg, exp_next;
    logic [rtfd_pkg::CntW-1:0] rcv_reg, rcv_next;
    logic [7:0] ego_reg, ego_next;
    logic [12:0] rx;
    logic [10:0] ry;
    logic [rtfd_pkg::CntW-1:0] clamped;
    logic [rtfd_pkg::CntW-1:0] rcv_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_id_reg <= 11'd10;
            tgt_id_reg <= 11'd11;
            exp_reg    <= '0;
            rcv_reg    <= '0;
            ego_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == rtfd_pkg::REG_HEADER_ID[0:0])
                hdr_id_reg <= cfg_data;
            if (cfg_we && cfg_index == rtfd_pkg::REG_TARGET_ID[0:0])
                tgt_id_reg <= cfg_data;
            exp_reg <= exp_next;
            rcv_reg <= rcv_next;
            ego_reg <= ego_next;
        end
    end

    assign rx      = {b1, b2[7:3]};
    assign ry      = {b2[2:0], b3};
    assign clamped = (b0 > 8'(rtfd_pkg::MaxTargets)) ? rtfd_pkg::CntW'(rtfd_pkg::MaxTargets)
                                                     : b0[rtfd_pkg::CntW-1:0];
    assign rcv_inc = rcv_reg + 1'b1;

    always_comb
    begin
        exp_next = exp_reg;
        rcv_next = rcv_reg;
        ego_next = ego_reg;
        cmd_push = 1'b0;
        cmd      = '0;
        if (in_fire)
        begin
            priority if (frame_id == hdr_id_reg)
            begin
                exp_next = clamped;
                rcv_next = '0;
                ego_next = b4;
                cmd.kind = rtfd_pkg::RESULT_EMPTY;
                cmd.last = 1'b1;
                cmd.ego  = b4;
                cmd_push = (clamped == '0);
            end
            else if (frame_id == tgt_id_reg)
            begin
                if (rcv_reg < rtfd_pkg::CntW'(rtfd_pkg::MaxTargets))
                begin
                    rcv_next   = rcv_inc;
                    cmd_push   = 1'b1;
                    cmd.kind   = rtfd_pkg::RESULT_TARGET;
                    cmd.index  = rcv_reg[5:0];
                    cmd.last   = (rcv_inc >= exp_reg);
                    cmd.dx     = 15'(signed'({2'b0, rx, 1'b0}) - 15'sd5000);
                    cmd.dy     = 13'(signed'({1'b0, ry, 1'b0}) - 13'sd2046);
                    cmd.raw_vx = {b4, b5[7:6]};
                    cmd.mclass = b6[2:0];
                    cmd.ego    = ego_reg;
                end
            end
        end
    end

endmodule

@@ rtl/rtfd_queue.sv @@
// Short command queue between front and back ends. Depends on rtfd_pkg.
module rtfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rtfd_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output rtfd_pkg::cmd_t pop_data
);

    rtfd_pkg::cmd_t mem_reg [rtfd_pkg::CmdDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rp_reg];

endmodule

@@ rtl/rtfd_back.sv @@
// Back end: iterative CORDIC bearing and bit-pair square root, one step
// per cycle, plus result register. Depends on rtfd_pkg.
module rtfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  rtfd_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output rtfd_pkg::res_t res
);

    rtfd_pkg::be_state_t state_reg, state_next;
    rtfd_pkg::cmd_t c_reg;
    logic signed [rtfd_pkg::AccW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [rtfd_pkg::ZW-1:0] z_reg, z_next;
    logic [rtfd_pkg::StepW-1:0] i_reg, i_next;
    logic [rtfd_pkg::SqW-1:0] n_reg, n_next;
    logic [rtfd_pkg::SqW-1:0] r_reg, r_next;
    logic [rtfd_pkg::SqW-1:0] bit_reg, bit_next;
    logic signed [rtfd_pkg::AccW-1:0] xs, ys;
    logic [13:0] ax, ay;
    logic [rtfd_pkg::SqW-1:0] sq;
    logic [rtfd_pkg::SqW:0] trial;
    logic signed [rtfd_pkg::ZW-1:0] zr;
    logic signed [rtfd_pkg::ZW-1:0] bq;
    logic signed [14:0] bear;
    logic [13:0] rng;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rtfd_pkg::BE_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rtfd_pkg::BE_IDLE && cmd_valid)
            c_reg <= cmd;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        i_reg   <= i_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign ax = 14'((cmd.dx < 0) ? -cmd.dx : cmd.dx);
    assign ay = 14'((cmd.dy < 0) ? -cmd.dy : cmd.dy);
    assign sq = {14'b0, ax} * {14'b0, ax} + {14'b0, ay} * {14'b0, ay};
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign trial = {1'b0, n_reg} - ({1'b0, r_reg} + {1'b0, bit_reg});

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        n_next = n_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        cmd_pop = 1'b0;
        unique case (state_reg)
            rtfd_pkg::BE_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    x_next  = rtfd_pkg::AccW'({ax, 16'b0});
                    y_next  = rtfd_pkg::AccW'((cmd.dx < 0) ? -cmd.dy : cmd.dy) <<< 16;
                    z_next  = '0;
                    i_next  = '0;
                    n_next  = sq;
                    r_next  = '0;
                    bit_next = {2'b01, {(rtfd_pkg::SqW - 2){1'b0}}};
                    state_next = rtfd_pkg::BE_RUN;
                end
            end
            rtfd_pkg::BE_RUN:
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + signed'(rtfd_pkg::atan_entry(i_reg));
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - signed'(rtfd_pkg::atan_entry(i_reg));
                end
                if (bit_reg != '0)
                begin
                    if (!trial[rtfd_pkg::SqW])
                    begin
                        n_next = trial[rtfd_pkg::SqW-1:0];
                        r_next = (r_reg >> 1) + bit_reg;
                    end
                    else
                        r_next = r_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == rtfd_pkg::StepW'(rtfd_pkg::CordicSteps - 1))
                    state_next = rtfd_pkg::BE_DONE;
            end
            rtfd_pkg::BE_DONE:
            begin
                if (res_ready)
                    state_next = rtfd_pkg::BE_IDLE;
            end
            default: state_next = rtfd_pkg::BE_IDLE;
        endcase
    end

    assign zr = z_reg + 20'sd4;
    assign bq = zr >>> 3;
    assign rng = (n_reg > r_reg) ? 14'(r_reg + 1'b1) : r_reg[13:0];

    always_comb
    begin
        if (c_reg.dx == 0)
            bear = (c_reg.dy > 0) ? 15'sd12868 : ((c_reg.dy < 0) ? -15'sd12868 : 15'sd0);
        else if (bq > 20'sd12868)
            bear = 15'sd12868;
        else if (bq < -20'sd12868)
            bear = -15'sd12868;
        else
            bear = bq[14:0];
    end

    assign res_valid = (state_reg == rtfd_pkg::BE_DONE);

    always_comb
    begin
        res = '0;
        res.kind  = c_reg.kind;
        res.last  = c_reg.last;
        res.ego   = c_reg.ego;
        if (c_reg.kind == rtfd_pkg::RESULT_TARGET)
        begin
            res.index   = c_reg.index;
            res.dx      = c_reg.dx;
            res.dy      = c_reg.dy;
            res.range_v = rng;
            res.bearing = bear;
            res.invalid = (c_reg.dx == 0) && (c_reg.dy == 0);
            res.vx      = signed'(c_reg.raw_vx ^ 10'h200);
            res.mclass  = c_reg.mclass;
        end
    end

endmodule

@@ rtl/radar_target_frame_decoder_unit.sv @@
// Top level of the radar target frame decoder: front end, command queue,
// back end. Depends on rtfd_pkg, rtfd_front, rtfd_queue, rtfd_back.
//
// channel | dir | payload
// s_axis  | in  | tdata: frame_id, data_b0..data_b6 (72 bits)
// m_axis  | out | tdata: fields of one result; tuser: result_kind
// cfg     | in  | cfg_we, cfg_index, cfg_data (11 bits)
//
// In the back end a target goes through load, 17 CORDIC steps with the
// square root sharing the same loop, and the result register. Headers
// with a nonzero count give nothing. Reset is asynchronous and clears
// counters and queue. A stalled output holds the back end; the front
// keeps taking frames until the two-entry queue is full.
module radar_target_frame_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // frame_id, b0..b6 from bit 11, 0 pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // index,dx,dy,range,bearing,invalid,vx,class,ego
    output logic        m_axis_tlast,   // last_of_list
    output logic        m_axis_tuser    // result_kind
);

    logic in_fire, push, full, pop, ne;
    rtfd_pkg::cmd_t cmd, qcmd;
    rtfd_pkg::res_t res;

    assign s_axis_tready = !full;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    rtfd_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_fire,
        .frame_id (s_axis_tdata[10:0]),
        .b0 (s_axis_tdata[18:11]), .b1 (s_axis_tdata[26:19]),
        .b2 (s_axis_tdata[34:27]), .b3 (s_axis_tdata[42:35]),
        .b4 (s_axis_tdata[50:43]), .b5 (s_axis_tdata[58:51]),
        .b6 (s_axis_tdata[66:59]),
        .cmd_push (push), .cmd
    );

    rtfd_queue u_queue (
        .clk, .rst_n, .push, .push_data (cmd), .full,
        .pop, .not_empty (ne), .pop_data (qcmd)
    );

    rtfd_back u_back (
        .clk, .rst_n, .cmd_valid (ne), .cmd (qcmd), .cmd_pop (pop),
        .res_valid (m_axis_tvalid), .res_ready (m_axis_tready), .res
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {3'b0, res.ego, res.mclass, res.vx, res.invalid, res.bearing,
                           res.range_v, res.dy, res.dx, res.index};

endmodule

@@ rtl/rtfd_checker.sv @@
// Port-level checker for radar_target_frame_decoder_unit, bound to the top.
// Depends on the top level's ports only.
module rtfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[76:0] == '0)
        else $error("empty list result malformed");

    a_no_back2back: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[62:48]) <= 15'sd12868
                       && $signed(m_axis_tdata[62:48]) >= -15'sd12868)
        else $error("bearing out of range");

endmodule

bind radar_target_frame_decoder_unit rtfd_checker u_rtfd_checker (.*);

@@ tb/radar_target_frame_decoder_unit_check.sv @@
`timescale 1ns / 1ps
// Checker for the radar target frame decoder: watches the frame, result and
// register ports, predicts every result and compares. Depends on rtfd_pkg.
module radar_target_frame_decoder_unit_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    output int          fails,
    output int          pending,
    output int          results_seen
);

    localparam longint AngleTab [0:16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    logic [10:0] hdr_id;
    logic [10:0] tgt_id;
    int unsigned want_cnt;
    int unsigned got_cnt;
    logic [7:0]  own_ego;
    rtfd_pkg::res_t decoded_q [$];

    function automatic longint bearing_calc(longint x, longint y);
        longint z, xs, ys, b;
        z = 0;
        if (x == 0)
            return (y > 0) ? rtfd_pkg::HalfPiOut
                           : ((y < 0) ? -rtfd_pkg::HalfPiOut : 0);
        if (x < 0)
        begin
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < 17; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + AngleTab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - AngleTab[i];
            end
        end
        b = (z + 4) >>> 3;
        if (b > rtfd_pkg::HalfPiOut)
            b = rtfd_pkg::HalfPiOut;
        if (b < -rtfd_pkg::HalfPiOut)
            b = -rtfd_pkg::HalfPiOut;
        return b;
    endfunction

    function automatic longint range_calc(longint s);
        longint r, t;
        r = 0;
        for (int k = 15; k >= 0; k--)
        begin
            t = r | (longint'(1) << k);
            if (t * t <= s)
                r = t;
        end
        if (s - r * r > r)
            r++;
        return r;
    endfunction

    task automatic decode_frame(input logic [71:0] d);
        logic [10:0] id;
        logic [7:0]  b [7];
        longint      rx, ry, dx, dy;
        rtfd_pkg::res_t e;
        id = d[10:0];
        for (int k = 0; k < 7; k++)
            b[k] = d[11 + 8 * k +: 8];
        e = '0;
        if (id == hdr_id)
        begin
            want_cnt = (b[0] > rtfd_pkg::MaxTargets) ? rtfd_pkg::MaxTargets : b[0];
            got_cnt  = 0;
            own_ego  = b[4];
            if (want_cnt == 0)
            begin
                e.kind = rtfd_pkg::RESULT_EMPTY;
                e.last = 1'b1;
                e.ego  = own_ego;
                decoded_q.push_back(e);
            end
        end
        else if (id == tgt_id && got_cnt < rtfd_pkg::MaxTargets)
        begin
            rx = {b[1], b[2][7:3]};
            ry = {b[2][2:0], b[3]};
            dx = rx * 2 - 5000;
            dy = ry * 2 - 2046;
            e.kind    = rtfd_pkg::RESULT_TARGET;
            e.index   = got_cnt[5:0];
            got_cnt++;
            e.last    = (got_cnt >= want_cnt);
            e.dx      = dx[14:0];
            e.dy      = dy[12:0];
            e.range_v = 14'(range_calc(dx * dx + dy * dy));
            e.bearing = 15'(bearing_calc(dx, dy));
            e.invalid = (dx == 0 && dy == 0);
            e.vx      = {b[4], b[5][7:6]} - 10'd512;
            e.mclass  = b[6][2:0];
            e.ego     = own_ego;
            decoded_q.push_back(e);
        end
    endtask

    task automatic field_check(input string name, input longint want, input longint got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rtfd_pkg::res_t e;
        if (!rst_n)
        begin
            hdr_id   = 11'd10;
            tgt_id   = 11'd11;
            want_cnt = 0;
            got_cnt  = 0;
            own_ego  = '0;
            fails    = 0;
            results_seen = 0;
            decoded_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (decoded_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
                end
                else
                begin
                    e = decoded_q.pop_front();
                    field_check("kind", e.kind, m_axis_tuser);
                    field_check("index", e.index, m_axis_tdata[5:0]);
                    field_check("last", e.last, m_axis_tlast);
                    field_check("dx", $unsigned(e.dx), m_axis_tdata[20:6]);
                    field_check("dy", $unsigned(e.dy), m_axis_tdata[33:21]);
                    field_check("range", e.range_v, m_axis_tdata[47:34]);
                    field_check("bearing", $unsigned(e.bearing), m_axis_tdata[62:48]);
                    field_check("invalid", e.invalid, m_axis_tdata[63]);
                    field_check("vx", $unsigned(e.vx), m_axis_tdata[73:64]);
                    field_check("class", e.mclass, m_axis_tdata[76:74]);
                    field_check("ego", e.ego, m_axis_tdata[84:77]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_frame(s_axis_tdata);
            if (cfg_we)
            begin
                if (cfg_index == rtfd_pkg::REG_HEADER_ID[0:0])
                    hdr_id = cfg_data;
                else
                    tgt_id = cfg_data;
            end
        end
        pending = decoded_q.size();
    end

endmodule

@@ tb/radar_target_frame_decoder_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the radar target frame decoder: drives frames, register
// writes and output backpressure. Depends on rtfd_pkg, the top level and the checker.
module radar_target_frame_decoder_unit_test;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    int          fails;
    int          pending;
    int          results_seen;

    int          tx_idle;      // percent chance the sender idles before a frame
    int          rx_mode;      // 0 always ready, 1 and 3 random stall, 2 one long hold
    int          hold_left;
    bit          hold_done;
    logic [10:0] hdr_id;
    logic [10:0] tgt_id;
    int          frames_sent;

    radar_target_frame_decoder_unit u_top (.*);

    radar_target_frame_decoder_unit_check u_check (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b1;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (rx_mode == 2 && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            if (hold_left >= 400)
                hold_done <= 1'b1;
            hold_left <= hold_left + 1;
        end
        else if (rx_mode == 1)
            m_axis_tready <= ($urandom_range(99) >= 53);
        else if (rx_mode == 3)
            m_axis_tready <= ($urandom_range(99) >= 33);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_frame(input logic [10:0] id, input logic [55:0] bytes);
        if ($urandom_range(99) < tx_idle)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(6)) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, bytes, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        frames_sent++;
    endtask

    task automatic send_header(input logic [7:0] count, input logic [7:0] ego);
        logic [55:0] bytes;
        bytes = 56'({$urandom(), $urandom()});
        bytes[7:0]   = count;
        bytes[39:32] = ego;
        send_frame(hdr_id, bytes);
    endtask

    task automatic send_target(input logic [12:0] rx, input logic [10:0] ry,
                               input logic [9:0] vx, input logic [2:0] cls);
        logic [55:0] bytes;
        bytes = 56'({$urandom(), $urandom()});
        bytes[31:8]  = {ry[7:0], rx[4:0], ry[10:8], rx[12:5]};
        bytes[39:32] = vx[9:2];
        bytes[47:46] = vx[1:0];
        bytes[50:48] = cls;
        send_frame(tgt_id, bytes);
    endtask

    task automatic send_random_target();
        logic [12:0] rx;
        logic [10:0] ry;
        rx = 13'($urandom_range(8191));
        ry = 11'($urandom_range(2047));
        case ($urandom_range(9))
            0: rx = 13'd2500;
            1: ry = 11'd1023;
            default: ;
        endcase
        send_target(rx, ry, 10'($urandom), 3'($urandom));
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == rtfd_pkg::REG_HEADER_ID[0:0])
            hdr_id = val;
        else
            tgt_id = val;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_traffic(input int quota);
        int start, n;
        start = frames_sent;
        while (frames_sent - start < quota)
        begin
            case ($urandom_range(99)) inside
                [0:7]:   send_frame(11'($urandom), 56'({$urandom(), $urandom()}));
                [8:14]:  send_header(8'd0, 8'($urandom));
                default:
                begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(255, 40)
                                                  : $urandom_range(6, 1);
                    send_header(8'(n), 8'($urandom));
                    if (n > 8)
                        n = $urandom_range(8, 1);
                    n = n + $urandom_range(1) - $urandom_range(1);
                    repeat (n) send_random_target();
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_idle       = 0;
        rx_mode       = 0;
        hdr_id        = 11'd10;
        tgt_id        = 11'd11;
        frames_sent   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: geometry corners, empty list, clamp, overrun, stray ids
        send_header(8'd4, 8'd255);
        send_target(13'd2500, 11'd1023, 10'd512, 3'd0);
        send_target(13'd2500, 11'd2047, 10'd0, 3'd1);
        send_target(13'd2500, 11'd0, 10'd1023, 3'd2);
        send_target(13'd0, 11'd0, 10'd1, 3'd3);
        send_target(13'd8191, 11'd2047, 10'd1023, 3'd7);
        send_target(13'd100, 11'd1500, 10'd300, 3'd4);
        send_target(13'd100, 11'd200, 10'd700, 3'd5);
        send_target(13'd8191, 11'd0, 10'd0, 3'd6);
        send_header(8'd0, 8'd77);
        send_header(8'd200, 8'd9);
        send_target(13'd0, 11'd2047, 10'd2, 3'd1);
        send_header(8'd64, 8'd0);
        send_header(8'd65, 8'd128);
        send_frame(11'd2047, 56'hFF_FFFF_FFFF_FFFF);
        send_frame(11'd0, 56'h0);
        send_header(8'd1, 8'd1);
        send_target(13'd2501, 11'd1024, 10'd511, 3'd0);
        random_traffic(200);
        drain();

        write_reg(rtfd_pkg::REG_HEADER_ID[0:0], 11'd0);
        write_reg(rtfd_pkg::REG_TARGET_ID[0:0], 11'd2047);
        tx_idle = 53;
        random_traffic(230);
        drain();

        write_reg(rtfd_pkg::REG_HEADER_ID[0:0], 11'd2047);
        write_reg(rtfd_pkg::REG_TARGET_ID[0:0], 11'd0);
        tx_idle = 0;
        rx_mode = 1;
        random_traffic(230);
        drain();

        write_reg(rtfd_pkg::REG_HEADER_ID[0:0], 11'd5);
        write_reg(rtfd_pkg::REG_TARGET_ID[0:0], 11'd5);
        tx_idle = 33;
        rx_mode = 3;
        random_traffic(120);
        drain();

        write_reg(rtfd_pkg::REG_HEADER_ID[0:0], 11'($urandom));
        write_reg(rtfd_pkg::REG_TARGET_ID[0:0], 11'($urandom));
        if (hdr_id == tgt_id)
            write_reg(rtfd_pkg::REG_TARGET_ID[0:0], ~hdr_id);
        tx_idle = 0;
        rx_mode = 2;
        send_header(8'd255, 8'($urandom));
        repeat (70) send_random_target();
        rx_mode = 0;
        random_traffic(270);
        drain();

        $display("Sent %0d frames, checked %0d results over five register settings,",
                 frames_sent, results_seen);
        $display("with sender gaps, output stalls, one long hold and a full list.");
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ radar_target_frame_decoder_unit.f @@
rtl/rtfd_pkg.sv
rtl/rtfd_front.sv
rtl/rtfd_queue.sv
rtl/rtfd_back.sv
rtl/radar_target_frame_decoder_unit.sv
rtl/rtfd_checker.sv
tb/radar_target_frame_decoder_unit_check.sv
tb/radar_target_frame_decoder_unit_test.sv
